### rtl/sptc_pkg.sv
`timescale 1ns / 1ps

package sptc_pkg;

    localparam int CELL_W       = 12;
    localparam int SIDE_W       = 7;
    localparam int TOTAL_W      = 2 * SIDE_W;
    localparam int TIME_W       = 32;
    localparam int HEIGHT_W     = 2;
    localparam int WORD_W       = HEIGHT_W + 1;
    localparam int MAX_SIDE_DEF = 64;
    localparam int SIDE_RESET   = 64;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 2'd3;
    localparam logic [TIME_W-1:0]   START_TIME = 32'd4;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_GRAIN = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic KIND_GRAIN  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [1:0] SEL_ONE  = 2'd0;
    localparam logic [1:0] SEL_SELF = 2'd1;
    localparam logic [1:0] SEL_NB   = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [CELL_W-1:0] cell_index;
        logic              from_self;
        logic [TIME_W-1:0] event_time;
    } t_in_item;

    typedef struct packed {
        logic                kind;
        logic [CELL_W-1:0]   dest_cell;
        logic [TIME_W-1:0]   send_time;
        logic [HEIGHT_W-1:0] cell_height;
        logic                ever_toppled;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic       capture;
        logic       rd_en;
        logic       wr_en;
        logic       clear;
        logic       div_start;
        logic       load;
        logic [1:0] sel;
        logic [1:0] dir;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       in_range;
        logic       from_self;
        logic       topple;
        logic       clr_done;
        logic       div_busy;
        logic       out_free;
    } t_status;

endpackage

### rtl/sptc_stream_if.sv
`timescale 1ns / 1ps

interface sptc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/sandpile_torus_cell_engine.sv
`timescale 1ns / 1ps
// Order: an input is captured, passes the decode, execute and emit states,
//   and its result is registered onto o_out; the four neighbor grains of a
//   toppling cell follow a column divider. A new item is taken only once the
//   last is dropped, stored or fully emitted; output stalls hold it longer.
// Reset: synchronous, active low; afterwards a clearing pass over all
//   MAX_SIDE * MAX_SIDE cells (4096 by default) holds input ready low.
module sandpile_torus_cell_engine
    import sptc_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIDE_W-1:0] i_cfg_wdata,
    sptc_stream_if.sink       i_in,
    sptc_stream_if.source     o_out
);
    t_cmd      cmd;
    t_status   status;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_payload;

    sptc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sptc_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_payload  (i_in.payload),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (out_valid),
        .o_out_payload (out_payload),
        .i_cmd         (cmd),
        .o_status      (status)
    );

    assign i_in.ready    = in_ready;
    assign o_out.valid   = out_valid;
    assign o_out.payload = out_payload;
endmodule

### rtl/sptc_ram.sv
`timescale 1ns / 1ps

module sptc_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/sptc_ctrl.sv
`timescale 1ns / 1ps

module sptc_ctrl
    import sptc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_DECODE    = 3'd2;
    localparam logic [2:0] S_EXEC      = 3'd3;
    localparam logic [2:0] S_EMIT_ONE  = 3'd4;
    localparam logic [2:0] S_EMIT_SELF = 3'd5;
    localparam logic [2:0] S_DIV       = 3'd6;
    localparam logic [2:0] S_EMIT_NB   = 3'd7;

    logic [2:0] r_state, n_state;
    logic [1:0] r_dir, n_dir;
    logic       in_ready;
    t_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_dir   <= DIR_UP;
        end else begin
            r_state <= n_state;
            r_dir   <= n_dir;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_dir    = r_dir;
        in_ready = 1'b0;
        cmd      = '0;
        cmd.dir  = r_dir;
        case (r_state)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                // drop out-of-grid cells and the unused opcode
                if (i_status.op == OP_START ||
                    ((i_status.op inside {OP_GRAIN, OP_READ}) && i_status.in_range)) begin
                    cmd.rd_en = 1'b1;
                    n_state   = S_EXEC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EXEC: begin
                case (i_status.op)
                    OP_START: begin
                        cmd.wr_en = 1'b1;
                        n_state   = S_EMIT_ONE;
                    end
                    OP_GRAIN: begin
                        cmd.wr_en     = 1'b1;
                        cmd.div_start = i_status.topple;
                        if (i_status.from_self) begin
                            n_state = S_EMIT_SELF;
                        end else if (i_status.topple) begin
                            n_state = S_DIV;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_EMIT_ONE;
                    end
                endcase
            end
            S_EMIT_ONE: begin
                if (i_status.out_free) begin
                    cmd.load = 1'b1;
                    cmd.sel  = SEL_ONE;
                    cmd.last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_EMIT_SELF: begin
                if (i_status.out_free) begin
                    cmd.load = 1'b1;
                    cmd.sel  = SEL_SELF;
                    cmd.last = !i_status.topple;
                    n_state  = i_status.topple ? S_DIV : S_IDLE;
                end
            end
            S_DIV: begin
                n_dir = DIR_UP;
                if (!i_status.div_busy) begin
                    n_state = S_EMIT_NB;
                end
            end
            S_EMIT_NB: begin
                if (i_status.out_free) begin
                    cmd.load = 1'b1;
                    cmd.sel  = SEL_NB;
                    cmd.last = (r_dir == DIR_LEFT);
                    n_dir    = r_dir + 2'd1;
                    if (r_dir == DIR_LEFT) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = in_ready;
    assign o_cmd      = cmd;
endmodule

### rtl/sptc_datapath.sv
`timescale 1ns / 1ps

module sptc_datapath
    import sptc_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIDE_W-1:0] i_cfg_wdata,
    input  t_in_item          i_in_payload,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output t_out_item         o_out_payload,
    input  t_cmd              i_cmd,
    output t_status           o_status
);
    localparam int CELLS   = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int DCNT_W  = $clog2(CELL_W);
    localparam int WIDE_W  = TOTAL_W + 1;

    function automatic logic [SIDE_W-1:0] f_clamp(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] s;
        s = v;
        if (v == '0) begin
            s = SIDE_W'(1);
        end else if (int'(v) > MAX_SIDE) begin
            s = SIDE_W'(MAX_SIDE);
        end
        return s;
    endfunction

    logic [SIDE_W-1:0]  r_side;
    logic [TOTAL_W-1:0] r_total;
    t_in_item           r_item;
    logic [ADDR_W-1:0]  r_clr_cnt;

    logic [SIDE_W-1:0]  r_div_rem;
    logic [CELL_W-1:0]  r_div_shift;
    logic [DCNT_W-1:0]  r_div_cnt;
    logic               r_div_busy;
    logic [SIDE_W:0]    div_trial;

    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;

    logic [TOTAL_W-1:0]  center;
    logic [ADDR_W-1:0]   cell_addr;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;
    logic [HEIGHT_W-1:0] rd_height;
    logic                rd_flag;
    logic                topple;
    logic                out_free;
    logic [TIME_W-1:0]   next_time;

    logic [WIDE_W-1:0]  c_w, s_w, t_w, down_sum, nb;
    logic [SIDE_W:0]    x_inc;

    // configuration; total is registered from the side, in the cycle after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= f_clamp(SIDE_W'(SIDE_RESET));
        end else if (i_cfg_we) begin
            r_side <= f_clamp(i_cfg_wdata);
        end
        r_total <= TOTAL_W'(r_side) * TOTAL_W'(r_side);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + ADDR_W'(1);
        end
    end

    // cell store: {toppled flag, height}
    assign center    = (r_total >> 1) -
                       (r_side[0] ? TOTAL_W'(0) : TOTAL_W'(r_side >> 1));
    assign cell_addr = (r_item.opcode == OP_START) ? ADDR_W'(center)
                                                   : ADDR_W'(r_item.cell_index);
    assign rd_height = ram_rdata[HEIGHT_W-1:0];
    assign rd_flag   = ram_rdata[HEIGHT_W];
    assign topple    = (rd_height == HEIGHT_MAX);

    always_comb begin
        ram_we    = i_cmd.wr_en || i_cmd.clear;
        ram_waddr = i_cmd.clear ? r_clr_cnt : cell_addr;
        if (i_cmd.clear) begin
            ram_wdata = '0;
        end else if (r_item.opcode == OP_START) begin
            ram_wdata = {rd_flag, HEIGHT_MAX};
        end else if (topple) begin
            ram_wdata = {1'b1, HEIGHT_W'(0)};
        end else begin
            ram_wdata = {rd_flag, rd_height + HEIGHT_W'(1)};
        end
    end

    sptc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (cell_addr),
        .o_rdata (ram_rdata)
    );

    // restoring divider, one quotient bit a cycle; only the column is kept
    assign div_trial = {r_div_rem, r_div_shift[CELL_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_div_cnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= '0;
        end else if (r_div_busy) begin
            r_div_cnt <= r_div_cnt + DCNT_W'(1);
            if (r_div_cnt == DCNT_W'(CELL_W - 1)) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_rem   <= '0;
            r_div_shift <= r_item.cell_index;
        end else if (r_div_busy) begin
            r_div_shift <= r_div_shift << 1;
            if (div_trial >= {1'b0, r_side}) begin
                r_div_rem <= SIDE_W'(div_trial - {1'b0, r_side});
            end else begin
                r_div_rem <= SIDE_W'(div_trial);
            end
        end
    end

    // neighbor address with torus wraparound
    assign c_w      = WIDE_W'(r_item.cell_index);
    assign s_w      = WIDE_W'(r_side);
    assign t_w      = WIDE_W'(r_total);
    assign down_sum = c_w + s_w;
    assign x_inc    = {1'b0, r_div_rem} + (SIDE_W + 1)'(1);

    always_comb begin
        case (i_cmd.dir)
            DIR_UP:    nb = (c_w >= s_w) ? c_w - s_w : c_w + t_w - s_w;
            DIR_RIGHT: nb = (x_inc == {1'b0, r_side}) ? c_w + WIDE_W'(1) - s_w
                                                      : c_w + WIDE_W'(1);
            DIR_DOWN:  nb = (down_sum >= t_w) ? down_sum - t_w : down_sum;
            DIR_LEFT:  nb = (r_div_rem == '0) ? c_w + s_w - WIDE_W'(1)
                                              : c_w - WIDE_W'(1);
            default:   nb = c_w;
        endcase
    end

    assign next_time = r_item.event_time + TIME_W'(1);

    always_comb begin
        n_out      = '0;
        n_out.last = i_cmd.last;
        n_out.kind = KIND_GRAIN;
        case (i_cmd.sel)
            SEL_ONE: begin
                if (r_item.opcode == OP_START) begin
                    n_out.dest_cell = CELL_W'(center);
                    n_out.send_time = START_TIME;
                end else begin
                    n_out.kind         = KIND_REPORT;
                    n_out.dest_cell    = r_item.cell_index;
                    n_out.cell_height  = rd_height;
                    n_out.ever_toppled = rd_flag;
                end
            end
            SEL_SELF: begin
                n_out.dest_cell = r_item.cell_index;
                n_out.send_time = next_time;
            end
            SEL_NB: begin
                n_out.dest_cell = CELL_W'(nb);
                n_out.send_time = next_time;
            end
            default: begin
                n_out.dest_cell = r_item.cell_index;
            end
        endcase
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_payload = r_out;

    always_comb begin
        o_status           = '0;
        o_status.op        = r_item.opcode;
        o_status.in_range  = TOTAL_W'(r_item.cell_index) < r_total;
        o_status.from_self = r_item.from_self;
        o_status.topple    = topple;
        o_status.clr_done  = (r_clr_cnt == ADDR_W'(CELLS - 1));
        o_status.div_busy  = r_div_busy;
        o_status.out_free  = out_free;
    end
endmodule

### rtl/sptc_checker.sv
`timescale 1ns / 1ps

module sptc_checker
    import sptc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_payload
);
    // reset clears the result register and starts the clearing pass
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("result or ready seen right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_payload))
        else $error("stalled result changed");

    // one item at a time: ready drops after each input transaction
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while busy");

    a_report_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.kind == KIND_REPORT |->
            i_out_payload.last && i_out_payload.send_time == '0)
        else $error("malformed cell report");

    a_grain_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_payload.kind == KIND_GRAIN |->
            i_out_payload.cell_height == '0 && !i_out_payload.ever_toppled)
        else $error("grain event carries report fields");
endmodule

bind sandpile_torus_cell_engine sptc_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);
